/* rtl/lbsd_pkg.sv */
// Shared constants and elaboration-time tables for the log band spectrum block.
// Depends on nothing; the top level, lbsd_log2, lbsd_exp2 and the testbench import it.
`timescale 1ns / 1ps

package lbsd_pkg;

	// Port field widths
	localparam int MAG_W      = 24;
	localparam int IDX_W      = 12;
	localparam int BAND_W     = 6;
	localparam int LEVEL_W    = 15;
	localparam int SR_W       = 19;
	localparam int BC_W       = 7;
	localparam int ORD_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 19;

	// Internal datapath widths
	localparam int MAX_BANDS = 64;
	localparam int LW        = 24;  // signed Q16 log values
	localparam int DQ_W      = 20;  // log span between 20 Hz and the top edge
	localparam int EW        = 55;  // Q30 edge position after the final shift
	localparam int MANT_W    = 31;  // Q30 mantissa in [1, 2)
	localparam int FRAC_W    = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSFORM_ORDER = 2'd2;

	localparam logic [SR_W-1:0]  SR_RESET  = 19'd48000;
	localparam logic [BC_W-1:0]  BC_RESET  = 7'd32;
	localparam logic [ORD_W-1:0] ORD_RESET = 4'd11;
	localparam logic [SR_W-1:0]  SR_MIN    = 19'd8000;
	localparam logic [SR_W-1:0]  SR_MAX    = 19'd384000;
	localparam logic [SR_W-1:0]  SR_HIGH   = 19'd40000;
	localparam logic [ORD_W-1:0] ORD_MIN   = 4'd10;
	localparam logic [ORD_W-1:0] ORD_MAX   = 4'd13;

	localparam logic [13:0] LEVEL_FLOOR     = 14'd15360;
	localparam logic [19:0] DB_PER_LOG2_Q16 = 20'd394566;
	localparam logic [31:0] ONE_Q16         = 32'd65536;
	localparam logic [31:0] ONE_Q30         = 32'd1073741824;
	localparam logic [31:0] LG_OFFSET       = 32'd2490368;  // 38.0 in Q16

	// Q16 log2 with the same truncated squaring as the hardware unit.
	function automatic logic [31:0] lg_q16_c(input logic [63:0] x);
		int msb;
		logic [63:0] y;
		logic [31:0] frac;
		msb = 0;
		for (int i = 0; i < 64; i++) begin
			if (x[i]) msb = i;
		end
		y = (msb >= 30) ? (x >> (msb - 30)) : (x << (30 - msb));
		frac = 32'd0;
		for (int j = 0; j < 16; j++) begin
			y = (y * y) >> 30;
			frac = {frac[30:0], 1'b0};
			if (y >= (64'd2 << 30)) begin
				y = y >> 1;
				frac[0] = 1'b1;
			end
		end
		return (32'(msb) << 16) + frac;
	endfunction

	function automatic logic [63:0] isqrt_c(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v = v_in;
		res = 64'd0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > v) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 64'd0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		return res;
	endfunction

	// Successive square roots of 2.0 in Q30; slot j-1 holds 2^(2^-j).
	function automatic logic [16*32-1:0] root_pack_c();
		logic [63:0] r;
		logic [16*32-1:0] p;
		r = 64'd2 << 30;
		p = '0;
		for (int j = 0; j < 16; j++) begin
			r = isqrt_c(r << 30);
			p[j*32 +: 32] = r[31:0];
		end
		return p;
	endfunction

	// log2(20 * 2^order) for order 10 to 13.
	function automatic logic [4*32-1:0] lg20n_pack_c();
		logic [4*32-1:0] p;
		p = '0;
		for (int i = 0; i < 4; i++) begin
			p[i*32 +: 32] = lg_q16_c(64'd20 << (10 + i));
		end
		return p;
	endfunction

	localparam logic [16*32-1:0] ROOT_PACK  = root_pack_c();
	localparam logic [4*32-1:0]  LG20N_PACK = lg20n_pack_c();
	localparam logic [31:0]      LG20_Q16   = lg_q16_c(64'd20);
	localparam logic [31:0]      LG20K_Q16  = lg_q16_c(64'd20000);

endpackage

/* rtl/log_band_spectrum_db_top.sv */
// Top level of the log band spectrum analyzer: bin store, band sequencer, level output.
// Depends on lbsd_pkg, lbsd_ram, lbsd_div, lbsd_log2 and lbsd_exp2.
`timescale 1ns / 1ps

// Bin words are written into the bin store at one per clock while busy is low.
// A word with frame_end set is stored and then starts the band pass, during
// which busy is high and no word is taken. The pass first takes log2 of the
// sample rate and then the exp2 of the lowest edge. Each band then runs a divide
// for the edge step, an exp2, one bin store read per bin, a divide for the
// average (40 + log2(MAX_BINS) bits wide, 52 by default) and, unless the
// average is zero, a log2. Every level appears on the result ports for exactly
// one cycle with result_strobe high; the receiver must take it then. With
// band_count at zero a frame end emits nothing. Bins never written in a frame
// read back as arbitrary data.
module log_band_spectrum_db_top
	import lbsd_pkg::*;
#(
	parameter int MAX_BINS = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [MAG_W-1:0]            magnitude,
	input  logic [IDX_W-1:0]            bin_index,
	input  logic                        frame_end,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	output logic                        result_strobe,
	output logic [BAND_W-1:0]           band_index,
	output logic signed [LEVEL_W-1:0]   level_db,
	output logic                        last_band
);

	localparam int AW  = $clog2(MAX_BINS);
	localparam int SW  = MAG_W + AW;
	localparam int NW  = SW + FRAC_W;
	localparam int CW  = AW + 1;
	localparam int LGW = FRAC_W + $clog2(NW);
	localparam int LOW = EW - 30;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_LGSR   = 12'b000000000010,
		S_PREP   = 12'b000000000100,
		S_EDGE0  = 12'b000000001000,
		S_DIVK   = 12'b000000010000,
		S_EXPK   = 12'b000000100000,
		S_BOUNDS = 12'b000001000000,
		S_SUM    = 12'b000010000000,
		S_AVG    = 12'b000100000000,
		S_LOG    = 12'b001000000000,
		S_MUL    = 12'b010000000000,
		S_EMIT   = 12'b100000000000
	} seq_state_t;

	seq_state_t state_q;

	logic [SR_W-1:0]  cfg_sr_q;
	logic [BC_W-1:0]  cfg_bc_q;
	logic [ORD_W-1:0] cfg_ord_q;

	logic [SR_W-1:0]        sr_q;
	logic [ORD_W-1:0]       ord_q;
	logic [BC_W-1:0]        n_q;
	logic [AW-1:0]          nbm1_q;
	logic [LGW-1:0]         lgsr_q;
	logic signed [LW-1:0]   a_q;
	logic [DQ_W-1:0]        d_q;
	logic [BC_W-1:0]        k_q;
	logic [EW-1:0]          edge_q;
	logic [EW-1:0]          next_q;
	logic [DQ_W-1:0]        quot_q;
	logic [AW-1:0]          lo_q;
	logic [AW-1:0]          hi_q;
	logic [AW-1:0]          b_q;
	logic                   issue_q;
	logic                   rd_s1;
	logic                   last_s1;
	logic [SW-1:0]          sum_q;
	logic [NW-1:0]          avg_q;
	logic                   avg_zero_q;
	logic [LGW-1:0]         lgv_q;
	logic [17:0]            qraw_q;
	logic                   lg_go_q;
	logic                   ex_go_q;
	logic                   div_go_q;
	logic                   strobe_q;
	logic [BAND_W-1:0]      band_q;
	logic signed [LEVEL_W-1:0] level_q;
	logic                   last_q;

	logic                   accept;
	logic                   ram_we;
	logic                   ram_re;
	logic [MAG_W-1:0]       ram_rdata;
	logic [SR_W-1:0]        sr_c;
	logic [ORD_W-1:0]       ord_c;
	logic [BC_W-1:0]        n_c;
	logic [14:0]            half_c;
	logic [14:0]            nb_c;
	logic [1:0]             ord_idx;
	logic [31:0]            lg20n;
	logic signed [LW-1:0]   lgsr_ext;
	logic signed [LW-1:0]   a_c;
	logic signed [LW-1:0]   lgmax_c;
	logic signed [LW-1:0]   d_c;
	logic [BC_W-1:0]        k1;
	logic [BC_W+DQ_W-1:0]   kd_c;
	logic signed [LW-1:0]   ex_l;
	logic                   ex_done;
	logic [EW-1:0]          ex_res;
	logic [NW-1:0]          div_num;
	logic [CW-1:0]          div_den;
	logic                   div_done;
	logic [NW-1:0]          div_quot;
	logic [NW-1:0]          lg_x;
	logic                   lg_done;
	logic [LGW-1:0]         lg_res;
	logic [LOW-1:0]         lo_full;
	logic [EW:0]            hi_sum;
	logic [LOW:0]           hi_full;
	logic [AW-1:0]          lo_c;
	logic [AW-1:0]          hi_c;
	logic [CW-1:0]          cnt_c;
	logic [LGW-1:0]         nlm_c;
	logic [LGW+20-1:0]      prod_c;
	logic [13:0]            qmin_c;
	logic                   last_c;

	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign ram_we = accept && ({1'b0, bin_index} < (IDX_W+1)'(MAX_BINS));
	assign ram_re = (state_q == S_SUM) && issue_q;

	// Register clamping and per-frame geometry.
	always_comb begin
		sr_c = (cfg_sr_q < SR_MIN) ? SR_MIN : ((cfg_sr_q > SR_MAX) ? SR_MAX : cfg_sr_q);
		ord_c = (cfg_ord_q < ORD_MIN) ? ORD_MIN :
			((cfg_ord_q > ORD_MAX) ? ORD_MAX : cfg_ord_q);
		n_c = (cfg_bc_q > BC_W'(MAX_BANDS)) ? BC_W'(MAX_BANDS) : cfg_bc_q;
		half_c = 15'd1 << (ord_c - 4'd1);
		nb_c = (half_c > 15'(MAX_BINS)) ? 15'(MAX_BINS) : half_c;
	end

	// Edge origin and log span.
	always_comb begin
		ord_idx = 2'(ord_q - ORD_MIN);
		lg20n = LG20N_PACK[{ord_idx, 5'b0} +: 32];
		lgsr_ext = $signed(LW'(lgsr_q));
		a_c = $signed(lg20n[LW-1:0]) - lgsr_ext;
		lgmax_c = (sr_q >= SR_HIGH) ? $signed(LG20K_Q16[LW-1:0])
			: lgsr_ext - $signed(ONE_Q16[LW-1:0]);
		d_c = lgmax_c - $signed(LG20_Q16[LW-1:0]);
		k1 = k_q + 1'b1;
		kd_c = (BC_W+DQ_W)'(k1) * (BC_W+DQ_W)'(d_q);
		ex_l = (state_q == S_EDGE0) ? a_q : a_q + $signed(LW'(quot_q));
	end

	// Shared unit operands.
	always_comb begin
		if (state_q == S_DIVK) begin
			div_num = NW'(kd_c);
			div_den = CW'(n_q);
		end else begin
			div_num = {sum_q, {FRAC_W{1'b0}}};
			div_den = cnt_c;
		end
		lg_x = (state_q == S_LGSR) ? NW'(sr_q) : avg_q;
	end

	// Band bounds in bins, clamped to the store.
	always_comb begin
		lo_full = edge_q[EW-1:30];
		hi_sum = {1'b0, next_q} + (EW+1)'(ONE_Q30 - 32'd1);
		hi_full = hi_sum[EW:30];
		lo_c = (lo_full > LOW'(nbm1_q)) ? nbm1_q : lo_full[AW-1:0];
		hi_c = (hi_full > (LOW+1)'(nbm1_q)) ? nbm1_q : hi_full[AW-1:0];
		if (hi_c < lo_c) hi_c = lo_c;
		cnt_c = {1'b0, hi_q} - {1'b0, lo_q} + CW'(1);
	end

	// dB conversion of the average.
	always_comb begin
		nlm_c = LGW'(LG_OFFSET) - lgv_q;
		prod_c = (LGW+20)'(nlm_c) * (LGW+20)'(DB_PER_LOG2_Q16) + (LGW+20)'(32'd8388608);
		qmin_c = (qraw_q > 18'(LEVEL_FLOOR)) ? LEVEL_FLOOR : qraw_q[13:0];
		last_c = (k_q == n_q - 1'b1);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_sr_q <= SR_RESET;
			cfg_bc_q <= BC_RESET;
			cfg_ord_q <= ORD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SAMPLE_RATE:     cfg_sr_q <= cfg_data;
				CFG_BAND_COUNT:      cfg_bc_q <= cfg_data[BC_W-1:0];
				CFG_TRANSFORM_ORDER: cfg_ord_q <= cfg_data[ORD_W-1:0];
				default: ;
			endcase
		end
	end

	// Band pass sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lg_go_q <= 1'b0;
			ex_go_q <= 1'b0;
			div_go_q <= 1'b0;
			issue_q <= 1'b0;
			rd_s1 <= 1'b0;
			last_s1 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			lg_go_q <= 1'b0;
			ex_go_q <= 1'b0;
			div_go_q <= 1'b0;
			strobe_q <= 1'b0;
			rd_s1 <= ram_re;
			last_s1 <= ram_re && (b_q == hi_q);
			case (state_q)
				S_IDLE: begin
					if (accept && frame_end && n_c != '0) begin
						state_q <= S_LGSR;
						lg_go_q <= 1'b1;
					end
				end
				S_LGSR: begin
					if (lg_done) state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= S_EDGE0;
					ex_go_q <= 1'b1;
				end
				S_EDGE0: begin
					if (ex_done) begin
						state_q <= S_DIVK;
						div_go_q <= 1'b1;
					end
				end
				S_DIVK: begin
					if (div_done) begin
						state_q <= S_EXPK;
						ex_go_q <= 1'b1;
					end
				end
				S_EXPK: begin
					if (ex_done) state_q <= S_BOUNDS;
				end
				S_BOUNDS: begin
					state_q <= S_SUM;
					issue_q <= 1'b1;
				end
				S_SUM: begin
					if (issue_q && b_q == hi_q) issue_q <= 1'b0;
					if (rd_s1 && last_s1) begin
						state_q <= S_AVG;
						div_go_q <= 1'b1;
					end
				end
				S_AVG: begin
					if (div_done) begin
						if (div_quot == '0) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_LOG;
							lg_go_q <= 1'b1;
						end
					end
				end
				S_LOG: begin
					if (lg_done) state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					strobe_q <= 1'b1;
					if (last_c) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIVK;
						div_go_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Band pass datapath.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept && frame_end) begin
			sr_q <= sr_c;
			ord_q <= ord_c;
			n_q <= n_c;
			nbm1_q <= AW'(nb_c - 15'd1);
		end
		if (state_q == S_LGSR && lg_done) lgsr_q <= lg_res;
		if (state_q == S_PREP) begin
			a_q <= a_c;
			d_q <= (d_c < 0) ? '0 : d_c[DQ_W-1:0];
			k_q <= '0;
		end
		if (state_q == S_EDGE0 && ex_done) edge_q <= ex_res;
		if (state_q == S_DIVK && div_done) quot_q <= div_quot[DQ_W-1:0];
		if (state_q == S_EXPK && ex_done) next_q <= ex_res;
		if (state_q == S_BOUNDS) begin
			lo_q <= lo_c;
			hi_q <= hi_c;
			b_q <= lo_c;
			sum_q <= '0;
		end
		if (state_q == S_SUM) begin
			if (issue_q && b_q != hi_q) b_q <= b_q + 1'b1;
			if (rd_s1) sum_q <= sum_q + SW'(ram_rdata);
		end
		if (state_q == S_AVG && div_done) begin
			avg_q <= div_quot;
			avg_zero_q <= (div_quot == '0);
		end
		if (state_q == S_LOG && lg_done) lgv_q <= lg_res;
		if (state_q == S_MUL) begin
			if (avg_zero_q) qraw_q <= 18'(LEVEL_FLOOR);
			else if (lgv_q >= LGW'(LG_OFFSET)) qraw_q <= '0;
			else qraw_q <= prod_c[LGW+20-1:24];
		end
		if (state_q == S_EMIT) begin
			band_q <= k_q[BAND_W-1:0];
			level_q <= -$signed({1'b0, qmin_c});
			last_q <= last_c;
			edge_q <= next_q;
			k_q <= k1;
		end
	end

	lbsd_ram #(
		.WIDTH(MAG_W),
		.DEPTH(MAX_BINS)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(bin_index[AW-1:0]),
		.wdata(magnitude),
		.re   (ram_re),
		.raddr(b_q),
		.rdata(ram_rdata)
	);

	lbsd_div #(
		.NW(NW),
		.DW(CW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (div_go_q),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	lbsd_log2 #(
		.XW(NW)
	) u_log2 (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (lg_go_q),
		.x     (lg_x),
		.done  (lg_done),
		.res   (lg_res)
	);

	lbsd_exp2 u_exp2 (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (ex_go_q),
		.l     (ex_l),
		.done  (ex_done),
		.res   (ex_res)
	);

	assign result_strobe = strobe_q;
	assign band_index = band_q;
	assign level_db = level_q;
	assign last_band = last_q;

`ifndef ASSERT_OFF
	// A level is only shown in the cycle after the emit step.
	a_strobe_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(state_q == S_EMIT))
		else $error("result strobe without emit step");

	// The bin sweep never runs past the band's upper bin.
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM && issue_q) |-> (b_q <= hi_q && lo_q <= hi_q))
		else $error("bin sweep out of band");

	// The final band of a frame returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last_band) |-> (state_q == S_IDLE))
		else $error("last band without return to idle");

	// Levels stay within the clamped range.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (level_db <= 15'sd0 && level_db >= -15'sd15360))
		else $error("level out of range");
`endif

endmodule

/* rtl/lbsd_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module lbsd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

/* rtl/lbsd_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps

module lbsd_div #(
	parameter int NW = 52,
	parameter int DW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    num_q;
	logic [DW-1:0]    den_q;
	logic [DW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DW:0]      rem_sh;
	logic             qbit;

	// One trial subtraction per cycle.
	always_comb begin
		rem_sh = {rem_q, num_q[NW-1]};
		qbit = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CNT_W'(NW - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= qbit ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
			num_q <= {num_q[NW-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

/* rtl/lbsd_log2.sv */
// Iterative Q16 log2: normalize one bit per cycle, then sixteen squaring steps.
// Depends on lbsd_pkg.
`timescale 1ns / 1ps

module lbsd_log2
	import lbsd_pkg::*;
#(
	parameter int XW = 52
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            go,
	input  logic [XW-1:0]                   x,
	output logic                            done,
	output logic [FRAC_W+$clog2(XW)-1:0]    res
);

	localparam int IW = $clog2(XW);

	typedef enum logic [2:0] {
		L_IDLE = 3'b001,
		L_NORM = 3'b010,
		L_SQR  = 3'b100
	} lg_state_t;

	lg_state_t         state_q;
	logic [XW-1:0]     x_q;
	logic [IW-1:0]     sh_q;
	logic [3:0]        step_q;
	logic [MANT_W-1:0] y_q;
	logic [FRAC_W-1:0] frac_q;
	logic              done_q;
	logic [FRAC_W+IW-1:0] res_q;
	logic [2*MANT_W-1:0]  sq;
	logic [MANT_W:0]      sq_hi;
	logic [MANT_W-1:0]    y_next;
	logic [FRAC_W-1:0]    frac_next;

	// Square the mantissa; a result of two or more yields a one bit.
	always_comb begin
		sq = (2*MANT_W)'(y_q) * (2*MANT_W)'(y_q);
		sq_hi = sq[2*MANT_W-1:MANT_W-1];
		y_next = sq_hi[MANT_W] ? sq_hi[MANT_W:1] : sq_hi[MANT_W-1:0];
		frac_next = {frac_q[FRAC_W-2:0], sq_hi[MANT_W]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q <= 1'b0;
			sh_q <= '0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (go) begin
						state_q <= L_NORM;
						sh_q <= '0;
					end
				end
				L_NORM: begin
					if (x_q[XW-1]) begin
						state_q <= L_SQR;
						step_q <= '0;
					end else begin
						sh_q <= sh_q + 1'b1;
					end
				end
				L_SQR: begin
					step_q <= step_q + 1'b1;
					if (step_q == 4'd15) begin
						state_q <= L_IDLE;
						done_q <= 1'b1;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == L_IDLE && go) begin
			x_q <= x;
		end else if (state_q == L_NORM) begin
			if (x_q[XW-1]) begin
				y_q <= x_q[XW-1 -: MANT_W];
				frac_q <= '0;
			end else begin
				x_q <= {x_q[XW-2:0], 1'b0};
			end
		end else if (state_q == L_SQR) begin
			y_q <= y_next;
			frac_q <= frac_next;
			if (step_q == 4'd15) res_q <= {IW'(XW - 1) - sh_q, frac_next};
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

/* rtl/lbsd_exp2.sv */
// Iterative exp2 of a signed Q16 value to a Q30 result, one root product per cycle.
// Depends on lbsd_pkg.
`timescale 1ns / 1ps

module lbsd_exp2
	import lbsd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic signed [LW-1:0] l,
	output logic                 done,
	output logic [EW-1:0]        res
);

	typedef enum logic [2:0] {
		E_IDLE  = 3'b001,
		E_RUN   = 3'b010,
		E_SHIFT = 3'b100
	} ex_state_t;

	ex_state_t          state_q;
	logic [3:0]         step_q;
	logic [FRAC_W-1:0]  f_q;
	logic signed [8:0]  ip_q;
	logic               zero_q;
	logic [MANT_W-1:0]  r_q;
	logic               done_q;
	logic [EW-1:0]      res_q;
	logic signed [LW:0] u;
	logic [31:0]        root;
	logic [62:0]        prod;
	logic [8:0]         nip;
	logic [EW-1:0]      shifted;

	// Offset so the integer part is nonnegative, then pick the root for this step.
	always_comb begin
		u = $signed({l[LW-1], l}) + $signed((LW+1)'(64) <<< 16);
		root = ROOT_PACK[{step_q, 5'b0} +: 32];
		prod = 63'(r_q) * 63'(root);
		nip = 9'(-ip_q);
		if (zero_q) begin
			shifted = '0;
		end else if (!ip_q[8]) begin
			shifted = EW'(r_q) << ((ip_q > 9'sd24) ? 9'd24 : 9'(ip_q));
		end else if (nip >= 9'd31) begin
			shifted = '0;
		end else begin
			shifted = EW'(r_q >> nip);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				E_IDLE: begin
					if (go) begin
						state_q <= (u < 0) ? E_SHIFT : E_RUN;
						step_q <= '0;
					end
				end
				E_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == 4'd15) state_q <= E_SHIFT;
				end
				E_SHIFT: begin
					state_q <= E_IDLE;
					done_q <= 1'b1;
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && go) begin
			zero_q <= (u < 0);
			f_q <= u[FRAC_W-1:0];
			ip_q <= $signed({1'b0, u[23:16]}) - 9'sd64;
			r_q <= ONE_Q30[MANT_W-1:0];
		end else if (state_q == E_RUN) begin
			if (f_q[4'd15 - step_q]) r_q <= prod[60:30];
		end else if (state_q == E_SHIFT) begin
			res_q <= shifted;
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

/* verif/log_band_spectrum_db_top_test.sv */
// Self-checking testbench for log_band_spectrum_db_top: bin words, frame ends, band levels.
// Depends on lbsd_pkg and the RTL of log_band_spectrum_db_top; reads no files.
`timescale 1ns / 1ps

module log_band_spectrum_db_top_test;
	import lbsd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int QUIET_CYCLES = 400;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int STORE_DEPTH = 4096;
	// Low bins written up front; every setting used keeps its bands inside them.
	localparam int FILL_BINS = 64;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic [MAG_W-1:0]      mag;
		logic [IDX_W-1:0]      bin;
		bit                    fe;
		int                    gap;
	} word_t;

	typedef struct {
		logic [BAND_W-1:0]         band;
		logic signed [LEVEL_W-1:0] level;
		bit                        last;
	} level_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [MAG_W-1:0] magnitude;
	logic [IDX_W-1:0] bin_index;
	logic frame_end;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic result_strobe;
	logic [BAND_W-1:0] band_index;
	logic signed [LEVEL_W-1:0] level_db;
	logic last_band;

	word_t  pending_words[$];
	level_t band_levels[$];
	int     error_count = 0;
	int     cycle_count = 0;
	int     quiet_count;
	int     gap_left;
	bit     burst_mode;

	// Mirror of the block's state.
	logic [MAG_W-1:0] shadow_store[STORE_DEPTH];
	logic [SR_W-1:0]  shadow_rate;
	logic [BC_W-1:0]  shadow_bands;
	logic [ORD_W-1:0] shadow_order;

	log_band_spectrum_db_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.magnitude(magnitude), .bin_index(bin_index), .frame_end(frame_end),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_strobe(result_strobe), .band_index(band_index),
		.level_db(level_db), .last_band(last_band)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Q16 log2 by truncated repeated squaring of the Q30 mantissa.
	function automatic longint log2_q16(input logic [63:0] x);
		int top;
		logic [63:0] y;
		longint frac;
		top = 0;
		frac = 0;
		if (x == 0) return 0;
		for (int i = 0; i < 64; i++) begin
			if (x[i]) top = i;
		end
		y = (top >= 30) ? (x >> (top - 30)) : (x << (30 - top));
		for (int j = 0; j < 16; j++) begin
			y = (y * y) >> 30;
			frac = frac << 1;
			if (y >= (64'd2 << 30)) begin
				y = y >> 1;
				frac = frac | 1;
			end
		end
		return (longint'(top) << 16) + frac;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v = v_in;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Power of two of a Q16 exponent, Q30 result.
	function automatic logic [63:0] pow2_q30(input longint l);
		longint u;
		longint ip;
		logic [15:0] f;
		logic [63:0] r;
		logic [63:0] root;
		u = l + (longint'(64) << 16);
		r = 64'd1 << 30;
		root = 64'd2 << 30;
		if (u < 0) return 0;
		ip = (u >>> 16) - 64;
		f = u[15:0];
		for (int j = 1; j <= 16; j++) begin
			root = int_sqrt(root << 30);
			if (f[16 - j]) r = (r * root) >> 30;
		end
		if (ip >= 0) return (ip > 24) ? (r << 24) : (r << ip);
		return (-ip >= 62) ? 64'd0 : (r >> (-ip));
	endfunction

	// Works out the level of every band when a frame ends.
	task automatic predict_band_levels();
		int n;
		longint rate;
		int order;
		longint nbins;
		longint a;
		longint d;
		longint top_lg;
		logic [63:0] edge_lo;
		logic [63:0] edge_hi;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] sum;
		logic [63:0] avg;
		longint lm;
		longint q;
		level_t e;
		n = (shadow_bands > MAX_BANDS) ? MAX_BANDS : shadow_bands;
		if (n == 0) return;
		rate = shadow_rate < 8000 ? 8000 : (shadow_rate > 384000 ? 384000 : shadow_rate);
		order = shadow_order < 10 ? 10 : (shadow_order > 13 ? 13 : shadow_order);
		nbins = longint'(1) << (order - 1);
		if (nbins > STORE_DEPTH) nbins = STORE_DEPTH;
		a = log2_q16(64'd20 << order) - log2_q16(rate);
		top_lg = (rate >= 40000) ? log2_q16(20000) : log2_q16(rate) - 65536;
		d = top_lg - log2_q16(20);
		if (d < 0) d = 0;
		edge_lo = pow2_q30(a);
		for (int k = 0; k < n; k++) begin
			edge_hi = pow2_q30(a + (longint'(k + 1) * d) / n);
			lo = edge_lo >> 30;
			hi = (edge_hi + (64'd1 << 30) - 1) >> 30;
			if (lo > nbins - 1) lo = nbins - 1;
			if (hi > nbins - 1) hi = nbins - 1;
			if (hi < lo) hi = lo;
			sum = 0;
			for (logic [63:0] b = lo; b <= hi; b++) sum += shadow_store[b];
			avg = (sum << 16) / (hi - lo + 1);
			if (avg == 0) begin
				q = 15360;
			end else begin
				lm = log2_q16(avg) - (longint'(38) << 16);
				if (lm >= 0) begin
					q = 0;
				end else begin
					q = ((-lm) * 394566 + (longint'(1) << 23)) >>> 24;
					if (q > 15360) q = 15360;
				end
			end
			e.band = k[BAND_W-1:0];
			e.level = -q[LEVEL_W-1:0];
			e.last = (k == n - 1);
			band_levels.push_back(e);
			edge_lo = edge_hi;
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// Gaps come in bursts with no idling and in stretches of random idling.
	function automatic int draw_gap();
		if ($urandom_range(0, 15) == 0) burst_mode = !burst_mode;
		return burst_mode ? 0 : $urandom_range(0, 19);
	endfunction

	task automatic push_bin(input logic [MAG_W-1:0] mag, input logic [IDX_W-1:0] bin,
			input bit fe);
		word_t w;
		w = '{default: 0};
		w.mag = mag;
		w.bin = bin;
		w.fe = fe;
		w.gap = draw_gap();
		pending_words.push_back(w);
	endtask

	task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		word_t w;
		w = '{default: 0};
		w.is_cfg = 1'b1;
		w.reg_idx = idx;
		w.reg_val = val;
		w.gap = draw_gap();
		pending_words.push_back(w);
	endtask

	task automatic push_settings(input int rate, input int bands, input int order);
		push_cfg(CFG_SAMPLE_RATE, rate[CFG_DATA_W-1:0]);
		push_cfg(CFG_BAND_COUNT, bands[CFG_DATA_W-1:0]);
		push_cfg(CFG_TRANSFORM_ORDER, order[CFG_DATA_W-1:0]);
	endtask

	function automatic logic [MAG_W-1:0] random_magnitude();
		return MAG_W'($urandom) >> $urandom_range(0, 23);
	endfunction

	// Driver: bin words and register writes, the latter only while the block is idle.
	always @(posedge clk or negedge arst_n) begin
		bit next_start;
		bit next_cfg;
		bit idle_ok;
		word_t w;
		if (!arst_n) begin
			start <= 1'b0;
			magnitude <= '0;
			bin_index <= '0;
			frame_end <= 1'b0;
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
			gap_left <= 0;
			quiet_count <= 0;
			shadow_rate = SR_RESET;
			shadow_bands = BC_RESET;
			shadow_order = ORD_RESET;
		end else begin
			next_start = start;
			next_cfg = cfg_valid;
			if (start && !busy) begin
				if (bin_index < STORE_DEPTH) shadow_store[bin_index] = magnitude;
				if (frame_end) predict_band_levels();
				next_start = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SAMPLE_RATE: shadow_rate = cfg_data[SR_W-1:0];
					CFG_BAND_COUNT: shadow_bands = cfg_data[BC_W-1:0];
					CFG_TRANSFORM_ORDER: shadow_order = cfg_data[ORD_W-1:0];
					default: ;
				endcase
				next_cfg = 1'b0;
			end
			quiet_count <= (band_levels.size() == 0 && !busy && !start) ? quiet_count + 1 : 0;
			if (!next_start && !next_cfg) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_words.size() > 0) begin
					w = pending_words[0];
					idle_ok = !w.is_cfg || (band_levels.size() == 0 && !busy
						&& quiet_count >= QUIET_CYCLES);
					if (idle_ok) begin
						void'(pending_words.pop_front());
						gap_left <= w.gap;
						if (w.is_cfg) begin
							next_cfg = 1'b1;
							cfg_index <= w.reg_idx;
							cfg_data <= w.reg_val;
						end else begin
							next_start = 1'b1;
							magnitude <= w.mag;
							bin_index <= w.bin;
							frame_end <= w.fe;
						end
					end
				end
			end
			start <= next_start;
			cfg_valid <= next_cfg;
		end
	end

	// Monitor: each strobed level against the oldest expected one.
	always @(posedge clk) begin
		level_t e;
		if (arst_n && result_strobe) begin
			if (band_levels.size() == 0) begin
				report_mismatch("unexpected level for band", band_index, -1);
			end else begin
				e = band_levels.pop_front();
				if (band_index !== e.band) report_mismatch("band_index", band_index, e.band);
				if (level_db !== e.level) report_mismatch("level_db", level_db, e.level);
				if (last_band !== e.last) report_mismatch("last_band", last_band, e.last);
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** log_band_spectrum_db_top: FAILED **");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		int bands;
		burst_mode = 1'b0;
		arst_n = 1'b0;

		// High sample rate and the shortest transform keep all bands in the low bins.
		push_settings(384000, 32, 10);
		for (int i = 0; i < FILL_BINS; i++)
			push_bin(random_magnitude(), i[IDX_W-1:0], i == FILL_BINS - 1);

		// Directed: silent low bins, full-scale low bins, tiny low bins.
		for (int i = 0; i < 6; i++) push_bin('0, i[IDX_W-1:0], 1'b0);
		push_bin('0, 12'd6, 1'b1);
		for (int i = 0; i < 6; i++) push_bin({MAG_W{1'b1}}, i[IDX_W-1:0], 1'b0);
		push_bin({MAG_W{1'b1}}, 12'd6, 1'b1);
		for (int i = 0; i < 4; i++) push_bin(24'd1, i[IDX_W-1:0], 1'b0);
		push_bin(24'd1, 12'd4095, 1'b1);

		// Directed: saturating and truncated settings, spare index, zero bands, one band.
		push_settings(524287, 127, 0);
		push_cfg(CFG_SPARE, {CFG_DATA_W{1'b1}});
		push_bin({MAG_W{1'b1}}, 12'd63, 1'b1);
		push_settings(352000, 0, 26);
		push_bin(24'h5a5a5a, 12'd20, 1'b1);
		push_settings(340000, 64, 10);
		push_bin(24'h000100, 12'd40, 1'b1);
		push_settings(384000, 1, 4);
		push_bin(24'h400000, 12'd1, 1'b1);

		// Random phases: a setting, then frames of random bins.
		for (int p = 0; p < 4; p++) begin
			bands = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
			push_settings($urandom_range(340000, 384000), bands, $urandom_range(0, 10));
			for (int i = 0; i < 6; i++)
				push_bin(random_magnitude(), IDX_W'($urandom_range(0, FILL_BINS - 1)),
					(i == 5) || ($urandom_range(0, 3) == 0));
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_words.size() == 0 && !start && !cfg_valid);
		wait (band_levels.size() == 0 && !busy);
		repeat (QUIET_CYCLES) @(posedge clk);
		if (error_count == 0 && band_levels.size() == 0) begin
			$display("** log_band_spectrum_db_top: PASSED **");
		end else begin
			$display("** log_band_spectrum_db_top: FAILED **");
		end
		$finish;
	end

endmodule
